/* rtl/core/ocpw_pkg.sv */
// Shared types, codes and the 6x8 font for the OLED character page writer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package ocpw_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_CONT   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam int GLYPH_COUNT   = 96;
    localparam int GLYPH_BYTES   = 6;
    localparam int QUEUE_DEPTH   = 2;
    localparam int BYTES_PER_CHR = 9;

    localparam logic [7:0] FIRST_CODE  = 8'd32;
    localparam logic [7:0] EDGE_COLUMN = 8'd126;
    localparam logic [7:0] MIN_COLUMN  = 8'd2;
    localparam logic [7:0] COL_ADVANCE = 8'd6;
    localparam logic [4:0] PAGE_CMD_HI = 5'b10110;   // 0xB0 + page
    localparam logic [3:0] COL_CMD_HI  = 4'h1;       // 0x10 | high nibble

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic       bad;
        logic [6:0] glyph_idx;
    } char_entry_t;

    // One glyph per row, byte 0 in the top bits
    localparam logic [47:0] GLYPH_ROM [GLYPH_COUNT] = '{
        48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
        48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
        48'h00001c224100, 48'h000041221c00, 48'h0014083e0814, 48'h0008083e0808,
        48'h000000a06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
        48'h003e5149453e, 48'h0000427f4000, 48'h004261514946, 48'h002141454b31,
        48'h001814127f10, 48'h002745454539, 48'h003c4a494930, 48'h000171090503,
        48'h003649494936, 48'h00064949291e, 48'h000036360000, 48'h000056360000,
        48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
        48'h00324959513e, 48'h007c1211127c, 48'h007f49494936, 48'h003e41414122,
        48'h007f4141221c, 48'h007f49494941, 48'h007f09090901, 48'h003e4149497a,
        48'h007f0808087f, 48'h0000417f4100, 48'h002040413f01, 48'h007f08142241,
        48'h007f40404040, 48'h007f020c027f, 48'h007f0408107f, 48'h003e4141413e,
        48'h007f09090906, 48'h003e4151215e, 48'h007f09192946, 48'h004649494931,
        48'h0001017f0101, 48'h003f4040403f, 48'h001f2040201f, 48'h003f4038403f,
        48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007f414100,
        48'h000204081020, 48'h000041417f00, 48'h000402010204, 48'h004040404040,
        48'h000001020400, 48'h002054545478, 48'h007f48444438, 48'h003844444420,
        48'h00384444487f, 48'h003854545418, 48'h00087e090102, 48'h0018a4a4a47c,
        48'h007f08040478, 48'h0000447d4000, 48'h004080847d00, 48'h007f10284400,
        48'h0000417f4000, 48'h007c04180478, 48'h007c08040478, 48'h003844444438,
        48'h00fc24242418, 48'h0018242418fc, 48'h007c08040408, 48'h004854545420,
        48'h00043f444020, 48'h003c4040207c, 48'h001c2040201c, 48'h003c4030403c,
        48'h004428102844, 48'h001ca0a0a07c, 48'h004464544c44, 48'h141414141414,
        48'h000000000000, 48'h000000000000, 48'h000000000000, 48'h000000000000
    };

    function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] sel);
        logic [47:0] row;
        logic [7:0]  res;
        begin
            row = GLYPH_ROM[idx];
            case (sel)
                3'd0:    res = row[47:40];
                3'd1:    res = row[39:32];
                3'd2:    res = row[31:24];
                3'd3:    res = row[23:16];
                3'd4:    res = row[15:8];
                3'd5:    res = row[7:0];
                default: res = 8'h00;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ocpw_front.sv */
// Front part: accepts character items, resolves column and page, keeps the cursor.
// Depends on ocpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocpw_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [6:0]           column,
    input  wire logic [2:0]           page,
    input  wire logic [7:0]           char_code,
    output logic                      push,
    output ocpw_pkg::char_entry_t     push_entry,
    input  wire logic                 q_full
);

    logic [7:0] cursor_column_reg, cursor_column_next;
    logic [2:0] cursor_page_reg, cursor_page_next;
    logic [7:0] src_col;
    logic [7:0] raised_col;
    logic [2:0] src_page;
    logic       wrap;
    logic [6:0] final_col;
    logic [2:0] final_page;
    logic       accept;
    logic [7:0] rel_code;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        src_col  = (operation == ocpw_pkg::OP_CONT) ? cursor_column_reg : {1'b0, column};
        src_page = (operation == ocpw_pkg::OP_CONT) ? cursor_page_reg : page;
        // raise low string columns to the left margin
        if ((operation != ocpw_pkg::OP_SINGLE) && (src_col < ocpw_pkg::MIN_COLUMN))
        begin
            raised_col = ocpw_pkg::MIN_COLUMN;
        end
        else
        begin
            raised_col = src_col;
        end
        wrap       = raised_col > ocpw_pkg::EDGE_COLUMN;
        final_col  = wrap ? ocpw_pkg::MIN_COLUMN[6:0] : raised_col[6:0];
        final_page = wrap ? src_page + 3'd1 : src_page;
    end

    assign rel_code = char_code - ocpw_pkg::FIRST_CODE;

    always_comb
    begin
        push_entry.page      = final_page;
        push_entry.column    = final_col;
        push_entry.bad       = char_code[7] | (char_code[7:5] == 3'd0);
        push_entry.glyph_idx = rel_code[6:0];
    end

    // drop the unused operation code
    assign push = accept & (operation != ocpw_pkg::OP_NONE);

    always_comb
    begin
        cursor_column_next = cursor_column_reg;
        cursor_page_next   = cursor_page_reg;
        if (push && (operation != ocpw_pkg::OP_SINGLE))
        begin
            cursor_column_next = {1'b0, final_col} + ocpw_pkg::COL_ADVANCE;
            cursor_page_next   = final_page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_column_reg <= 8'd0;
            cursor_page_reg   <= 3'd0;
        end
        else
        begin
            cursor_column_reg <= cursor_column_next;
            cursor_page_reg   <= cursor_page_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ocpw_queue.sv */
// Short register queue of resolved character entries between front and back.
// Depends on ocpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocpw_queue
#(
    parameter int DEPTH = ocpw_pkg::QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ocpw_pkg::char_entry_t push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output ocpw_pkg::char_entry_t     head,
    output logic                      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ocpw_pkg::char_entry_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ocpw_back.sv */
// Back part: turns each queued entry into three command bytes and six glyph bytes.
// Depends on ocpw_pkg (font and entry type).
`timescale 1ns / 1ps
`default_nettype none

module ocpw_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ocpw_pkg::char_entry_t head,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 byte_value,
    output logic                       is_data,
    output logic                       last,
    output logic                       bad_code
);

    localparam logic [3:0] STEP_PAGE   = 4'd0;
    localparam logic [3:0] STEP_COL_HI = 4'd1;
    localparam logic [3:0] STEP_COL_LO = 4'd2;
    localparam logic [3:0] STEP_GLYPH  = 4'd3;
    localparam logic [3:0] STEP_LAST   = 4'(ocpw_pkg::BYTES_PER_CHR - 1);

    logic [3:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       data_reg, data_next;
    logic       last_reg, last_next;
    logic       bad_reg, bad_next;
    logic       load;
    logic [3:0] glyph_step;
    logic [7:0] cur_byte;

    assign load       = ~valid_reg | out_ready;
    assign pop        = load & ~empty & (step_reg == STEP_LAST);
    assign glyph_step = step_reg - STEP_GLYPH;

    always_comb
    begin
        unique case (step_reg)
            STEP_PAGE:   cur_byte = {ocpw_pkg::PAGE_CMD_HI, head.page};
            STEP_COL_HI: cur_byte = {ocpw_pkg::COL_CMD_HI, 1'b0, head.column[6:4]};
            STEP_COL_LO: cur_byte = {4'h0, head.column[3:0]};
            default:     cur_byte = head.bad ? 8'h00
                                    : ocpw_pkg::glyph_byte(head.glyph_idx, glyph_step[2:0]);
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;
        if (load)
        begin
            valid_next = ~empty;
            if (!empty)
            begin
                byte_next = cur_byte;
                data_next = (step_reg >= STEP_GLYPH);
                last_next = (step_reg == STEP_LAST);
                bad_next  = head.bad;
                step_next = (step_reg == STEP_LAST) ? STEP_PAGE : step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_PAGE;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        data_reg <= data_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign out_valid  = valid_reg;
    assign byte_value = byte_reg;
    assign is_data    = data_reg;
    assign last       = last_reg;
    assign bad_code   = bad_reg;

endmodule

`default_nettype wire

/* rtl/core/oled_char_page_writer.sv */
// OLED character page writer: input item of one character, output stream of display bytes.
// Top level; instantiates ocpw_front, ocpw_queue and ocpw_back; depends on ocpw_pkg.
//
// Usage:
//   s_axis carries one character item: tuser holds the operation (single char at a
//   position, start a string at a position, continue at the kept cursor), tdata the
//   column, page and character code. The unused operation code is accepted and dropped.
//   m_axis carries the display bytes: three commands (page, column high, column low)
//   then six glyph bytes from the 6x8 font; tlast marks the ninth byte, tuser flags
//   glyph data and a code outside the font.
//   The first byte of an item reaches the output register after the queue slot holds it.
//   Throughput: one output byte per cycle while m_axis_tready is high and the queue
//   holds an entry; the back part walks the nine bytes of the queue head.
//   The front part resolves the cursor on acceptance, so the next item is taken while
//   the back part still emits earlier bytes, until the QUEUE_DEPTH entry queue fills.
//   When the receiver stalls, the output register holds its byte and the queue fills;
//   s_axis_tready then drops. Reset clears the cursor to column 0, page 0 and empties
//   the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module oled_char_page_writer
#(
    parameter int QUEUE_DEPTH = ocpw_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // column[6:0], page[9:7], char_code[17:10], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // byte_value[7:0]
    output logic [1:0]       m_axis_tuser,   // is_data[0], bad_code[1]
    output logic             m_axis_tlast
);

    ocpw_pkg::char_entry_t push_entry;
    ocpw_pkg::char_entry_t head;
    logic push, q_full, pop, q_empty;
    logic is_data, bad_code;

    ocpw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .operation  (s_axis_tuser),
        .column     (s_axis_tdata[6:0]),
        .page       (s_axis_tdata[9:7]),
        .char_code  (s_axis_tdata[17:10]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    ocpw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    ocpw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .byte_value (m_axis_tdata),
        .is_data    (is_data),
        .last       (m_axis_tlast),
        .bad_code   (bad_code)
    );

    assign m_axis_tuser = {bad_code, is_data};

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> is_data)
        else $error("last byte is not a glyph byte");

    a_bad_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && bad_code && is_data |-> m_axis_tdata == 8'h00)
        else $error("bad code drew a non-blank glyph byte");

    a_cmd_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !(m_axis_tvalid && is_data))
        else $error("item did not start with a command byte");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue written while full");

endmodule

`default_nettype wire
